/* hw/rtl/pstt_pkg.sv */
// Package for the periodic software timer table: sizes, command and status codes.
package pstt_pkg;

  // Table size and derived widths
  localparam int TIMER_SLOTS = 16;
  localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);

  // Field widths
  localparam int CMD_W    = 3;
  localparam int HANDLE_W = 8;
  localparam int VALUE_W  = 32;
  localparam int HOUT_W   = 6;
  localparam int STAT_W   = 2;
  localparam int TICK_W   = 16;

  // Tick unit after reset
  localparam logic [TICK_W-1:0] TICK_UNIT_RST = TICK_W'(100);

  // Period value that marks an entry as invalid
  localparam logic [VALUE_W-1:0] INVALID_VAL = '1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CREATE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_START  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STOP   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STATUS = 3'd4;

  // Entry status codes
  localparam logic [STAT_W-1:0] ST_NOT_USED = 2'd0;
  localparam logic [STAT_W-1:0] ST_RUNNING  = 2'd1;
  localparam logic [STAT_W-1:0] ST_STOPPED  = 2'd2;

  // One table word: period in the upper half, count in the lower half
  typedef struct packed {
    logic [VALUE_W-1:0] reload;
    logic [VALUE_W-1:0] current;
  } slot_word_t;

endpackage

/* hw/rtl/pstt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module pstt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/pstt_slot_alu.sv */
// Shared per-slot unit: compare the count with the tick unit, then decrement or reload.
module pstt_slot_alu (
  input  pstt_pkg::slot_word_t              word_in,
  input  logic [pstt_pkg::TICK_W-1:0]       tick_unit,
  output logic                              expire,
  output logic [pstt_pkg::VALUE_W-1:0]      current_next
);

  logic [pstt_pkg::VALUE_W-1:0] unit_ext;

  assign unit_ext = pstt_pkg::VALUE_W'(tick_unit);

  // Expire when the count has reached the tick unit; otherwise count down
  always_comb begin
    expire = (word_in.current <= unit_ext);
    if (expire) begin
      current_next = word_in.reload;
    end else begin
      current_next = word_in.current - unit_ext;
    end
  end

endmodule

/* hw/rtl/periodic_software_timer_table.sv */
// Top level of the periodic software timer table: command sequencer, slot table, result register.
//
//  channel  | direction | transaction content
//  ---------+-----------+------------------------------------------------------------
//  s_*      | in        | tuser: cmd; tdata: handle, value
//  m_*      | out       | tuser: error, expired; tdata: handle_out, timer_status,
//           |           | any_active; tlast: last result of one command
//  cfg_*    | in        | cfg_data: tick_unit, always ready
//
// Create, start, stop and status: capture, then apply and load the result.
// A tick makes one table read per slot through the single RAM read port and the shared
// compare/subtract unit, then loads the final result.
// A full output register held by the sink stalls the sequencer when a result must enter it.
// Sync reset clears the status table and counters and presets the tick unit; RAM needs no clear.
// s_tready is high only while the sequencer is idle.
module periodic_software_timer_table (
  input  logic        clk,
  input  logic        rst,
  // command input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [7:0] handle, [39:8] value
  input  logic [2:0]  s_tuser,   // [2:0] cmd
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [5:0] handle_out, [7:6] timer_status, [8] any_active
  output logic [1:0]  m_tuser,   // [0] error, [1] expired
  output logic        m_tlast,
  // tick unit register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int SLOTS  = pstt_pkg::TIMER_SLOTS;
  localparam int SW     = pstt_pkg::SLOT_W;
  localparam int CW     = pstt_pkg::CNT_W;
  localparam int HW     = pstt_pkg::HANDLE_W;
  localparam int VW     = pstt_pkg::VALUE_W;
  localparam int OW     = pstt_pkg::HOUT_W;
  localparam int STW    = pstt_pkg::STAT_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMD   = 2'd1;
  localparam logic [1:0] S_TICK  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

  logic [1:0]                     state;
  logic [pstt_pkg::CMD_W-1:0]     cmd_q;
  logic [HW-1:0]                  handle_q;
  logic [VW-1:0]                  value_q;
  logic [pstt_pkg::TICK_W-1:0]    tick_unit;
  logic [STW-1:0]                 status_tbl [SLOTS];
  logic [CW-1:0]                  created_count;
  logic [CW-1:0]                  active_count;
  logic [CW-1:0]                  active_next;
  logic [CW-1:0]                  created_next;
  logic [SW-1:0]                  slot;
  logic [SW-1:0]                  pend_slot;
  logic                           pend_vld;

  logic                           s_xfer;
  logic                           out_free;
  logic [SW-1:0]                  h_idx;
  logic [SW-1:0]                  stat_idx;
  logic [STW-1:0]                 stat_rd;
  logic                           bad_handle;
  logic                           full;
  logic                           run;
  logic                           expire;
  logic [VW-1:0]                  current_next;
  logic                           stall;
  logic                           tick_step;
  logic                           cmd_done;
  logic                           cmd_err;

  logic                           ram_we;
  logic [SW-1:0]                  ram_waddr;
  pstt_pkg::slot_word_t           ram_wdata;
  logic [SW-1:0]                  ram_raddr;
  pstt_pkg::slot_word_t           ram_rdata;

  // Result push
  logic                           push;
  logic                           push_err;
  logic                           push_exp;
  logic                           push_last;
  logic [OW-1:0]                  push_handle;
  logic [STW-1:0]                 push_status;
  logic                           push_active;

  assign s_tready  = (state == S_IDLE);
  assign s_xfer    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  // Status table read: tick walks by slot, other commands use the handle
  assign h_idx    = handle_q[SW-1:0];
  assign stat_idx = (state == S_TICK) ? slot : h_idx;
  assign stat_rd  = status_tbl[stat_idx];

  assign bad_handle = (handle_q >= HW'(created_count));
  assign full       = (created_count == CW'(SLOTS));

  // Slot table and shared update unit
  pstt_ram #(
    .WIDTH ($bits(pstt_pkg::slot_word_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pstt_slot_alu u_alu (
    .word_in      (ram_rdata),
    .tick_unit    (tick_unit),
    .expire       (expire),
    .current_next (current_next)
  );

  // Tick walk control: a second expiry waits until the pending one can leave
  assign run       = (state == S_TICK) && (stat_rd == pstt_pkg::ST_RUNNING);
  assign stall     = run && expire && pend_vld && !out_free;
  assign tick_step = (state == S_TICK) && !stall;
  assign cmd_done  = (state == S_CMD) && out_free;

  always_comb begin
    if (state == S_TICK) begin
      ram_raddr = stall ? slot : slot + SW'(1);
    end else begin
      ram_raddr = '0;
    end
  end

  // Command decode and counter updates
  always_comb begin
    active_next  = active_count;
    created_next = created_count;
    cmd_err      = 1'b0;
    push_handle  = '0;
    push_status  = pstt_pkg::ST_NOT_USED;
    unique case (cmd_q)
      pstt_pkg::CMD_TICK: begin
        cmd_err = 1'b0;
      end
      pstt_pkg::CMD_CREATE: begin
        cmd_err = full;
        if (!full) begin
          created_next = created_count + CW'(1);
          push_handle  = OW'(created_count);
        end
      end
      pstt_pkg::CMD_START: begin
        cmd_err = bad_handle || (value_q == pstt_pkg::INVALID_VAL);
        if (!cmd_err && ((active_count == '0) || (stat_rd != pstt_pkg::ST_RUNNING))) begin
          active_next = active_count + CW'(1);
        end
      end
      pstt_pkg::CMD_STOP: begin
        cmd_err = bad_handle;
        if (!bad_handle && (stat_rd == pstt_pkg::ST_RUNNING) && (active_count != '0)) begin
          active_next = active_count - CW'(1);
        end
      end
      pstt_pkg::CMD_STATUS: begin
        cmd_err = bad_handle;
        if (!bad_handle) begin
          push_status = stat_rd;
        end
      end
      default: begin
        cmd_err = 1'b1;
      end
    endcase
  end

  // RAM write: start loads both halves, tick writes back the updated count
  always_comb begin
    ram_we             = 1'b0;
    ram_waddr          = h_idx;
    ram_wdata.reload   = value_q;
    ram_wdata.current  = value_q;
    if (tick_step && run) begin
      ram_we            = 1'b1;
      ram_waddr         = slot;
      ram_wdata.reload  = ram_rdata.reload;
      ram_wdata.current = current_next;
    end else if (cmd_done && (cmd_q == pstt_pkg::CMD_START) && !cmd_err) begin
      ram_we = 1'b1;
    end
  end

  // Result selection
  always_comb begin
    push        = 1'b0;
    push_err    = 1'b0;
    push_exp    = 1'b0;
    push_last   = 1'b1;
    push_active = (active_count != '0);
    unique case (state)
      S_CMD: begin
        push        = out_free;
        push_err    = cmd_err;
        push_active = (active_next != '0);
      end
      S_TICK: begin
        push      = tick_step && run && expire && pend_vld;
        push_exp  = 1'b1;
        push_last = 1'b0;
      end
      S_FLUSH: begin
        push     = out_free;
        push_exp = pend_vld;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      slot     <= '0;
      pend_vld <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_xfer) begin
            slot     <= '0;
            pend_vld <= 1'b0;
            state    <= (s_tuser == pstt_pkg::CMD_TICK) ? S_TICK : S_CMD;
          end
        end
        S_CMD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_TICK: begin
          if (tick_step) begin
            if (run && expire) begin
              pend_vld <= 1'b1;
            end
            if (slot == LAST_SLOT) begin
              state <= S_FLUSH;
            end else begin
              slot <= slot + SW'(1);
            end
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            pend_vld <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Pending expiry handle
  always_ff @(posedge clk) begin
    if (tick_step && run && expire) begin
      pend_slot <= slot;
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      cmd_q    <= s_tuser;
      handle_q <= s_tdata[HW-1:0];
      value_q  <= s_tdata[HW+VW-1:HW];
    end
  end

  // Tick unit register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_unit <= pstt_pkg::TICK_UNIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      tick_unit <= cfg_data;
    end
  end

  // Counters and entry status
  always_ff @(posedge clk) begin
    if (rst) begin
      created_count <= '0;
      active_count  <= '0;
      for (int k = 0; k < SLOTS; k++) begin
        status_tbl[k] <= pstt_pkg::ST_NOT_USED;
      end
    end else if (cmd_done) begin
      created_count <= created_next;
      active_count  <= active_next;
      if (!cmd_err) begin
        if (cmd_q == pstt_pkg::CMD_START) begin
          status_tbl[h_idx] <= pstt_pkg::ST_RUNNING;
        end else if (cmd_q == pstt_pkg::CMD_STOP) begin
          status_tbl[h_idx] <= pstt_pkg::ST_STOPPED;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      m_tuser <= {push_exp, push_err};
      m_tlast <= push_last;
      m_tdata <= {7'd0, push_active, push_status,
                  (push_exp ? OW'(pend_slot) : push_handle)};
    end
  end

endmodule

/* test/tb_top.sv */
// Self-checking testbench for periodic_software_timer_table: random stream traffic, shadow timer table.
`timescale 1ns / 1ps

module tb_top;
  import pstt_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;
  localparam int SETTLE_CYCLES  = TIMER_SLOTS + 8;
  localparam int TAIL_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SHOWN_FAILS    = 10;

  typedef enum logic [1:0] {ITEM_CMD, ITEM_CFG, ITEM_DRAIN} item_kind_t;

  // one queued transaction for the command or register channel
  typedef struct packed {
    item_kind_t          kind;
    logic [CMD_W-1:0]    cmd;
    logic [HANDLE_W-1:0] hnd;
    logic [VALUE_W-1:0]  period;  // tick unit in the low bits on a register write
  } stim_item_t;

  typedef struct packed {
    logic              error;
    logic [HOUT_W-1:0] handle_out;
    logic [STAT_W-1:0] timer_status;
    logic              expired;
    logic              any_active;
    logic              last;
  } timer_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;     // [7:0] handle, [39:8] value
  logic [2:0]  s_tuser = '0;     // [2:0] cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;          // [5:0] handle_out, [7:6] timer_status, [8] any_active
  logic [1:0]  m_tuser;          // [0] error, [1] expired
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  periodic_software_timer_table uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // shadow copy of the timer table
  logic [VALUE_W-1:0] reload_val [TIMER_SLOTS];
  logic [VALUE_W-1:0] cur_val    [TIMER_SLOTS];
  logic [STAT_W-1:0]  slot_state [TIMER_SLOTS];
  logic [CNT_W-1:0]   created_cnt;
  logic [CNT_W-1:0]   active_cnt;
  logic [TICK_W-1:0]  tick_unit_q;

  stim_item_t    cmd_queue[$];
  timer_result_t due_results[$];
  int            gen_created = 0;
  int            fail_count = 0;
  int            gap_left = 0;
  int            stall_left = 0;
  int            settle_left = SETTLE_CYCLES;
  int            quiet_cycles = 0;
  bit            drv_calm = 1'b0;
  bit            sink_calm = 1'b0;
  logic          s_fire = 1'b0;
  logic          cfg_fire = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_idle(bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // apply one command to the shadow table and queue the results it owes
  function automatic void run_timer_cmd(logic [CMD_W-1:0] cmd, logic [HANDLE_W-1:0] hnd,
                                        logic [VALUE_W-1:0] period);
    timer_result_t      r;
    int                 fired[$];
    logic               bad;
    logic [VALUE_W-1:0] prev;
    int                 idx;
    bad = (hnd >= created_cnt) || (hnd >= TIMER_SLOTS);
    idx = hnd;
    r = '0;
    r.last = 1'b1;
    case (cmd)
      CMD_TICK: begin
        for (int i = 0; i < TIMER_SLOTS; i++) begin
          if (i < created_cnt && cur_val[i] != INVALID_VAL && slot_state[i] != ST_STOPPED) begin
            if (cur_val[i] > tick_unit_q) begin
              cur_val[i] = cur_val[i] - tick_unit_q;
            end else begin
              cur_val[i] = reload_val[i];
              fired.push_back(i);
            end
          end
        end
        r.any_active = (active_cnt != 0);
        foreach (fired[k]) begin
          r.handle_out = HOUT_W'(fired[k]);
          r.expired = 1'b1;
          r.last = (k == fired.size() - 1);
          due_results.push_back(r);
        end
        // tick with nothing expiring still answers once
        if (fired.size() == 0) due_results.push_back(r);
      end
      CMD_CREATE: begin
        if (created_cnt >= TIMER_SLOTS) begin
          r.error = 1'b1;
        end else begin
          r.handle_out = HOUT_W'(created_cnt);
          created_cnt = created_cnt + 1'b1;
        end
      end
      CMD_START: begin
        if (bad || period == INVALID_VAL) begin
          r.error = 1'b1;
        end else begin
          prev = reload_val[idx];
          reload_val[idx] = period;
          cur_val[idx] = period;
          slot_state[idx] = ST_RUNNING;
          if (active_cnt == 0 || prev == INVALID_VAL) active_cnt = active_cnt + 1'b1;
        end
      end
      CMD_STOP: begin
        if (bad) begin
          r.error = 1'b1;
        end else begin
          if (reload_val[idx] != INVALID_VAL && active_cnt != 0) active_cnt = active_cnt - 1'b1;
          reload_val[idx] = INVALID_VAL;
          cur_val[idx] = INVALID_VAL;
          slot_state[idx] = ST_STOPPED;
        end
      end
      CMD_STATUS: begin
        if (bad) r.error = 1'b1;
        else r.timer_status = slot_state[idx];
      end
      default: begin
        r.error = 1'b1;
      end
    endcase
    if (cmd != CMD_TICK) begin
      r.any_active = (active_cnt != 0);
      due_results.push_back(r);
    end
  endfunction

  function automatic string result_text(timer_result_t r);
    return $sformatf("err=%0b hout=%0d st=%0d exp=%0b act=%0b last=%0b", r.error,
                     r.handle_out, r.timer_status, r.expired, r.any_active, r.last);
  endfunction

  function automatic void flag_failure(string what, timer_result_t want, timer_result_t got);
    fail_count++;
    if (fail_count <= SHOWN_FAILS)
      $display("%0t %s: expected %s, got %s", $time, what, result_text(want), result_text(got));
  endfunction

  // command and register driver, fed from cmd_queue
  always @(negedge clk) begin : drive_commands
    stim_item_t head;
    logic       nxt_valid;
    logic       nxt_cfg;
    nxt_valid = s_tvalid && !s_fire;
    nxt_cfg = cfg_valid && !cfg_fire;
    if (s_tvalid && s_fire) begin
      if ($urandom_range(0, 39) == 0) drv_calm = !drv_calm;
      gap_left = pick_idle(drv_calm);
    end
    if (!rst && !nxt_valid && !nxt_cfg && cmd_queue.size() != 0) begin
      head = cmd_queue[0];
      if (head.kind == ITEM_CMD) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          void'(cmd_queue.pop_front());
          s_tdata <= {head.period, head.hnd};
          s_tuser <= head.cmd;
          nxt_valid = 1'b1;
        end
      end else if (due_results.size() != 0) begin
        // hold off until every owed result is in, then let the block settle
        settle_left = SETTLE_CYCLES;
      end else if (settle_left > 0) begin
        settle_left--;
      end else begin
        void'(cmd_queue.pop_front());
        settle_left = SETTLE_CYCLES;
        if (head.kind == ITEM_CFG) begin
          cfg_data <= head.period[TICK_W-1:0];
          nxt_cfg = 1'b1;
        end
      end
    end
    s_tvalid <= nxt_valid;
    cfg_valid <= nxt_cfg;
  end

  // result sink with random back-pressure
  always @(negedge clk) begin : pace_results
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 29) == 0) sink_calm = !sink_calm;
        stall_left = pick_idle(sink_calm);
      end
    end
  end

  // transaction monitor: update the shadow table and check results
  always @(posedge clk) begin : watch_ports
    timer_result_t got;
    timer_result_t want;
    s_fire <= s_tvalid && s_tready;
    cfg_fire <= cfg_valid && cfg_ready;
    if (rst) begin
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        reload_val[i] = INVALID_VAL;
        cur_val[i] = INVALID_VAL;
        slot_state[i] = ST_NOT_USED;
      end
      created_cnt = '0;
      active_cnt = '0;
      tick_unit_q = TICK_UNIT_RST;
    end else begin
      if (cfg_valid && cfg_ready) tick_unit_q = cfg_data;
      if (s_tvalid && s_tready) run_timer_cmd(s_tuser, s_tdata[7:0], s_tdata[39:8]);
      if (m_tvalid && m_tready) begin
        got = {m_tuser[0], m_tdata[5:0], m_tdata[7:6], m_tuser[1], m_tdata[8], m_tlast};
        if (due_results.size() == 0) begin
          flag_failure("unexpected result", '0, got);
        end else begin
          want = due_results.pop_front();
          if (got !== want) flag_failure("result mismatch", want, got);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("periodic_software_timer_table regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void queue_cmd(logic [CMD_W-1:0] cmd, logic [HANDLE_W-1:0] hnd,
                                    logic [VALUE_W-1:0] period);
    cmd_queue.push_back('{ITEM_CMD, cmd, hnd, period});
    if (cmd == CMD_CREATE && gen_created < TIMER_SLOTS) gen_created++;
  endfunction

  function automatic void queue_cfg(logic [TICK_W-1:0] unit);
    cmd_queue.push_back('{ITEM_CFG, CMD_TICK, '0, VALUE_W'(unit)});
  endfunction

  // periods mostly a few ticks long so that expiries are frequent
  function automatic logic [VALUE_W-1:0] pick_period(int unit);
    int roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return '0;
    if (roll == 1) return INVALID_VAL;
    if (roll == 2) return $urandom;
    if (roll == 3) return INVALID_VAL - 1;
    return $urandom_range(1, 6 * unit + 1);
  endfunction

  // well-formed traffic with random content, some bad handles and unknown commands
  function automatic void queue_random(int count, int unit);
    int                  roll;
    logic [HANDLE_W-1:0] hnd;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (gen_created > 0 && $urandom_range(0, 7) != 0)
        hnd = HANDLE_W'($urandom_range(0, gen_created - 1));
      else hnd = HANDLE_W'($urandom_range(0, 255));
      if (roll < 35) queue_cmd(CMD_TICK, hnd, $urandom);
      else if (roll < 47) queue_cmd(CMD_CREATE, hnd, $urandom);
      else if (roll < 72) queue_cmd(CMD_START, hnd, pick_period(unit));
      else if (roll < 82) queue_cmd(CMD_STOP, hnd, $urandom);
      else if (roll < 95) queue_cmd(CMD_STATUS, hnd, $urandom);
      else queue_cmd(CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)), hnd, $urandom);
      // sender waits for the result stream to run dry
      if ($urandom_range(0, 59) == 0) cmd_queue.push_back('{ITEM_DRAIN, CMD_TICK, '0, '0});
    end
  endfunction

  // stimulus and end of run
  initial begin : run_regression
    int unit;
    // directed part at the reset tick unit
    queue_cmd(CMD_STATUS, 0, 0);
    queue_cmd(CMD_TICK, 0, 0);
    queue_cmd(CMD_CREATE, 0, 0);
    queue_cmd(CMD_CREATE, 8'hFF, INVALID_VAL);
    queue_cmd(CMD_CREATE, 0, 0);
    queue_cmd(CMD_START, 0, 0);
    queue_cmd(CMD_START, 1, 250);
    queue_cmd(CMD_START, 2, INVALID_VAL);
    queue_cmd(CMD_START, 8'hFF, 5);
    queue_cmd(CMD_START, 3, 5);
    queue_cmd(CMD_STATUS, 2, 0);
    queue_cmd(CMD_STATUS, 1, 0);
    queue_cmd(CMD_TICK, 0, 0);
    queue_cmd(CMD_TICK, 0, 0);
    queue_cmd(CMD_TICK, 0, 0);
    queue_cmd(CMD_START, 1, 100);
    queue_cmd(CMD_TICK, 0, 0);
    queue_cmd(CMD_STOP, 1, 0);
    queue_cmd(CMD_STOP, 2, 0);
    queue_cmd(CMD_STOP, 1, 0);
    queue_cmd(CMD_STATUS, 1, 0);
    queue_cmd(CMD_START, 2, INVALID_VAL - 1);
    queue_cmd(CMD_UNUSED_FIRST, 8'h5A, 32'hA5A5_A5A5);
    queue_cmd(CMD_UNUSED_LAST, 8'hA5, 32'h5A5A_5A5A);
    queue_cmd(CMD_TICK, 0, 0);
    // random phases across tick unit settings
    queue_cfg(1);
    queue_random(35, 1);
    queue_cfg(0);
    queue_random(20, 0);
    queue_cfg(16'hFFFF);
    queue_random(30, 65535);
    unit = $urandom_range(50, 500);
    queue_cfg(TICK_W'(unit));
    queue_random(45, unit);
    // fill the table, then one create too many
    while (gen_created < TIMER_SLOTS) queue_cmd(CMD_CREATE, HANDLE_W'($urandom), $urandom);
    queue_cmd(CMD_CREATE, HANDLE_W'($urandom), $urandom);
    repeat (3) queue_cmd(CMD_TICK, HANDLE_W'($urandom), $urandom);

    while (cmd_queue.size() != 0 || s_tvalid || cfg_valid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("periodic_software_timer_table regression: pass");
    end else begin
      $display("periodic_software_timer_table regression: fail");
    end
    $finish;
  end

endmodule
